### sv/mrae_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrae_pkg: shared definitions for the multichannel register ALU execute stage
// Command codes, field widths, comparator modes and the ALU status record.
// ----------------------------------------------------------------------------
package mrae_pkg;

   localparam int unsigned REG_ADDR_WIDTH_DEF = 6;
   localparam int unsigned CHANNELS_DEF       = 8;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned CMD_W       = 5;
   localparam int unsigned CH_W        = 3;
   localparam int unsigned ADDR_W      = 6;
   localparam int unsigned MODE_W      = 2;
   localparam int unsigned REQ_TDATA_W = 64;
   localparam int unsigned RSP_TDATA_W = 32;
   localparam int unsigned RSP_TUSER_W = 2;

   localparam logic [WORD_W-1:0] ALL_ONES = 32'hffff_ffff;
   localparam logic [WORD_W-1:0] MAG_MASK = 32'h7fff_ffff;
   localparam logic [WORD_W-1:0] SIGN_BIT = 32'h8000_0000;

   localparam logic [MODE_W-1:0] MODE_FULL   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REDUCE = 2'd1;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_NOP       = 5'd0,
      CMD_STOP      = 5'd1,
      CMD_AND       = 5'd2,
      CMD_OR        = 5'd3,
      CMD_XOR       = 5'd4,
      CMD_SATP      = 5'd5,
      CMD_SATN      = 5'd6,
      CMD_EQ        = 5'd7,
      CMD_NE        = 5'd8,
      CMD_GT        = 5'd9,
      CMD_LE        = 5'd10,
      CMD_BSET      = 5'd11,
      CMD_BSEL      = 5'd12,
      CMD_NOT       = 5'd13,
      CMD_ABS       = 5'd14,
      CMD_POPCNT    = 5'd15,
      CMD_LDC       = 5'd16,
      CMD_HOSTWRITE = 5'd17,
      CMD_HOSTREAD  = 5'd18,
      CMD_BROADCAST = 5'd19
   } command_type;

   typedef struct packed {
      logic wr;
      logic err;
      logic to_src_a;
   } alu_status_type;

endpackage
`default_nettype wire

### sv/mrae_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrae_alu: result logic for the register operations
// Bitwise, not, float min/max, sign-magnitude compares, bit set/select, abs, popcount, constant load.
// ----------------------------------------------------------------------------
module mrae_alu (
   input  logic [mrae_pkg::CMD_W-1:0]  cmd,
   input  logic [mrae_pkg::MODE_W-1:0] mode,
   input  mrae_pkg::word_type          src_a_val,
   input  mrae_pkg::word_type          src_b_val,
   input  mrae_pkg::word_type          dest_val,
   input  mrae_pkg::word_type          konst,
   output mrae_pkg::word_type          result,
   output mrae_pkg::alu_status_type    status
);
   import mrae_pkg::*;

   function automatic logic is_nan(input word_type x);
      return (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
   endfunction

   function automatic logic float_less(input word_type x, input word_type y);
      word_type kx;
      word_type ky;
      kx = x[31] ? ~x : (x | SIGN_BIT);
      ky = y[31] ? ~y : (y | SIGN_BIT);
      if (is_nan(x) || is_nan(y)) return 1'b0;
      if (((x & MAG_MASK) == '0) && ((y & MAG_MASK) == '0)) return 1'b0;
      return kx < ky;
   endfunction

   function automatic logic sm_greater(input word_type x, input word_type y);
      if (x[31] && y[31]) return x < y;
      if (x[31]) return 1'b0;
      if (y[31]) return 1'b1;
      return x > y;
   endfunction

   logic     eq_t;
   logic     gt_t;
   logic     cmp_t;
   word_type bit_mask;

   assign eq_t     = (src_a_val == src_b_val);
   assign gt_t     = sm_greater(src_a_val, src_b_val);
   assign cmp_t    = (cmd == CMD_EQ) ? eq_t :
                     (cmd == CMD_NE) ? !eq_t :
                     (cmd == CMD_GT) ? gt_t : (eq_t || !gt_t);
   assign bit_mask = word_type'(1) << src_b_val[4:0];

   always_comb begin
      result          = '0;
      status.wr       = 1'b1;
      status.err      = 1'b0;
      status.to_src_a = 1'b0;
      unique case (cmd)
         CMD_AND: result = src_a_val & src_b_val;
         CMD_OR:  result = src_a_val | src_b_val;
         CMD_XOR: result = src_a_val ^ src_b_val;
         CMD_SATP: result = float_less(src_b_val, src_a_val) ? src_b_val : src_a_val;
         CMD_SATN: result = float_less(src_a_val, src_b_val) ? src_b_val : src_a_val;
         CMD_EQ, CMD_NE, CMD_GT, CMD_LE: begin
            if (mode == MODE_FULL) begin
               result = cmp_t ? ALL_ONES : '0;
            end else if (mode == MODE_REDUCE) begin
               result = {31'd0, cmp_t};
            end else begin
               status.wr  = 1'b0;
               status.err = 1'b1;
            end
         end
         CMD_BSET: begin
            result          = (dest_val != '0) ? (src_a_val | bit_mask)
                                               : (src_a_val & ~bit_mask);
            status.to_src_a = 1'b1;
         end
         CMD_BSEL:   result = {31'd0, src_a_val[src_b_val[4:0]]};
         CMD_NOT:    result = ~src_a_val;
         CMD_ABS:    result = src_a_val & MAG_MASK;
         CMD_POPCNT: result = WORD_W'($countones(src_a_val));
         CMD_LDC:    result = konst;
         default:    status.wr = 1'b0;
      endcase
   end

endmodule
`default_nettype wire

### sv/multichannel_register_alu_execute.sv
// Path: stage 1 registers the request, the response register its result.
// Throughput: one instruction per cycle unless rsp_tready stalls; register
// reads and the write-back overlap, with the previous write forwarded into
// the next instruction. Reset: synchronous; the register file is swept to
// zero one row (all channels of one register address) a cycle with req_tready
// low till all rows clear. Configuration writes are taken during the sweep.
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_register_alu_execute: per-channel register file execute stage
// Reads up to three registers, computes one result and writes it back.
// ----------------------------------------------------------------------------
module multichannel_register_alu_execute #(
   parameter int unsigned REG_ADDR_WIDTH = mrae_pkg::REG_ADDR_WIDTH_DEF,
   parameter int unsigned CHANNELS       = mrae_pkg::CHANNELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // command[4:0] channel[7:5] round_start[8] dest[14:9] src_a[20:15]
   // src_b[26:21] constant[58:27], zeros above
   input  logic [mrae_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_data[31:0]
   output logic [mrae_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // error[0] skipped[1]
   output logic [mrae_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                             csr_we,
   input  logic [mrae_pkg::MODE_W-1:0]      csr_wdata
);
   import mrae_pkg::*;

   localparam int unsigned ROWS   = 1 << REG_ADDR_WIDTH;
   localparam int unsigned LANE_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef logic [CHANNELS-1:0][WORD_W-1:0] row_type;
   typedef logic [REG_ADDR_WIDTH-1:0]       rowaddr_type;
   typedef logic [LANE_W-1:0]               lane_type;

   row_type mem_x [ROWS];
   row_type mem_y [ROWS];
   row_type rd_a_ff;
   row_type rd_b_ff;
   row_type rd_d_ff;

   logic                clr_busy_ff;
   rowaddr_type         clr_row_ff;
   logic [MODE_W-1:0]   mode_ff;
   logic                stopped_ff;
   logic                stopped_in;

   logic                s1_valid_ff;
   logic [CMD_W-1:0]    s1_cmd_ff;
   logic [CH_W-1:0]     s1_ch_ff;
   logic                s1_rs_ff;
   rowaddr_type         s1_dest_ff;
   rowaddr_type         s1_srca_ff;
   rowaddr_type         s1_srcb_ff;
   word_type            s1_k_ff;

   logic                fwd_valid_ff;
   rowaddr_type         fwd_row_ff;
   logic [CHANNELS-1:0] fwd_mask_ff;
   word_type            fwd_data_ff;

   logic                rsp_valid_ff;
   word_type            rsp_data_ff;
   logic                rsp_err_ff;
   logic                rsp_skip_ff;

   rowaddr_type         req_row_a;
   rowaddr_type         req_row_b;
   rowaddr_type         req_row_d;
   logic                req_acc;
   logic                s1_adv;

   lane_type            s1_lane;
   logic                s1_present;
   logic [CHANNELS-1:0] lane_onehot;
   word_type            a_val;
   word_type            b_val;
   word_type            d_val;

   word_type            alu_result;
   alu_status_type      alu_status;

   logic                wr_en;
   rowaddr_type         wr_row;
   logic [CHANNELS-1:0] wr_mask;
   word_type            wr_data;
   word_type            out_data;
   logic                out_err;
   logic                out_skip;

   logic                mem_we;
   rowaddr_type         mem_row;
   logic [CHANNELS-1:0] mem_mask;
   word_type            mem_data;

   assign req_row_d = REG_ADDR_WIDTH'(req_tdata[14:9]);
   assign req_row_a = REG_ADDR_WIDTH'(req_tdata[20:15]);
   assign req_row_b = REG_ADDR_WIDTH'(req_tdata[26:21]);

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clr_busy_ff && (!s1_valid_ff || s1_adv);
   assign req_acc    = req_tvalid && req_tready;

   assign s1_lane    = LANE_W'(s1_ch_ff);
   assign s1_present = (32'(s1_ch_ff) < CHANNELS);

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         lane_onehot[i] = (LANE_W'(i) == s1_lane);
      end
   end

   // forward the write that landed on the same edge as the reads
   always_comb begin
      a_val = rd_a_ff[s1_lane];
      b_val = rd_b_ff[s1_lane];
      d_val = rd_d_ff[s1_lane];
      if (fwd_valid_ff && fwd_mask_ff[s1_lane]) begin
         if (fwd_row_ff == s1_srca_ff) a_val = fwd_data_ff;
         if (fwd_row_ff == s1_srcb_ff) b_val = fwd_data_ff;
         if (fwd_row_ff == s1_dest_ff) d_val = fwd_data_ff;
      end
   end

   mrae_alu u_alu (
      .cmd       (s1_cmd_ff),
      .mode      (mode_ff),
      .src_a_val (a_val),
      .src_b_val (b_val),
      .dest_val  (d_val),
      .konst     (s1_k_ff),
      .result    (alu_result),
      .status    (alu_status)
   );

   always_comb begin
      wr_en      = 1'b0;
      wr_row     = s1_dest_ff;
      wr_mask    = lane_onehot;
      wr_data    = s1_k_ff;
      out_data   = '0;
      out_err    = 1'b0;
      out_skip   = 1'b0;
      stopped_in = stopped_ff && !s1_rs_ff;
      priority if (s1_cmd_ff == CMD_BROADCAST) begin
         wr_en    = 1'b1;
         wr_mask  = '1;
         out_data = s1_k_ff;
      end else if (s1_cmd_ff == CMD_HOSTWRITE) begin
         if (s1_present) begin
            wr_en    = 1'b1;
            out_data = s1_k_ff;
         end
      end else if (s1_cmd_ff == CMD_HOSTREAD) begin
         if (s1_present) out_data = d_val;
      end else if (s1_cmd_ff <= CMD_LDC && stopped_in) begin
         out_skip = 1'b1;
      end else if (s1_cmd_ff == CMD_STOP) begin
         stopped_in = 1'b1;
      end else if (s1_cmd_ff >= CMD_AND && s1_cmd_ff <= CMD_LDC && s1_present) begin
         wr_en    = alu_status.wr;
         wr_row   = alu_status.to_src_a ? s1_srca_ff : s1_dest_ff;
         wr_data  = alu_result;
         out_data = alu_status.wr ? alu_result : '0;
         out_err  = alu_status.err;
      end else begin
         wr_en = 1'b0;
      end
   end

   assign mem_we   = clr_busy_ff || (s1_adv && wr_en);
   assign mem_row  = clr_busy_ff ? clr_row_ff : wr_row;
   assign mem_mask = clr_busy_ff ? '1 : wr_mask;
   assign mem_data = clr_busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      for (int i = 0; i < CHANNELS; i++) begin
         if (mem_we && mem_mask[i]) begin
            mem_x[mem_row][i] <= mem_data;
            mem_y[mem_row][i] <= mem_data;
         end
      end
      if (req_acc) begin
         rd_a_ff <= mem_x[req_row_a];
         rd_d_ff <= mem_x[req_row_d];
         rd_b_ff <= mem_y[req_row_b];
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_cmd_ff   <= req_tdata[4:0];
         s1_ch_ff    <= req_tdata[7:5];
         s1_rs_ff    <= req_tdata[8];
         s1_dest_ff  <= req_row_d;
         s1_srca_ff  <= req_row_a;
         s1_srcb_ff  <= req_row_b;
         s1_k_ff     <= req_tdata[58:27];
         fwd_row_ff  <= wr_row;
         fwd_mask_ff <= wr_mask;
         fwd_data_ff <= wr_data;
      end
      if (s1_adv) begin
         rsp_data_ff <= out_data;
         rsp_err_ff  <= out_err;
         rsp_skip_ff <= out_skip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_row_ff   <= '0;
         mode_ff      <= MODE_FULL;
         stopped_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_row_ff <= clr_row_ff + 1'b1;
            if (clr_row_ff == REG_ADDR_WIDTH'(ROWS - 1)) clr_busy_ff <= 1'b0;
         end
         if (csr_we) mode_ff <= csr_wdata;
         if (s1_adv) stopped_ff <= stopped_in;
         if (req_acc) begin
            s1_valid_ff  <= 1'b1;
            fwd_valid_ff <= s1_adv && wr_en;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_skip_ff, rsp_err_ff};

endmodule
`default_nettype wire

### sv/mrae_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrae_checker: port-level checks for the register ALU execute stage
// Watches reset, response hold and the error/skip result encoding.
// ----------------------------------------------------------------------------
module mrae_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [mrae_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [mrae_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import mrae_pkg::*;

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("stage not quiet after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_err_skip_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("error and skipped both set");

   a_flag_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] || rsp_tuser[1]) |-> rsp_tdata == '0)
      else $error("flagged response carries data");

endmodule

bind multichannel_register_alu_execute mrae_checker u_mrae_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
